>>> src/fais_pkg.sv
// fais_pkg: shared sizes, command/status codes, FSM states and the table
// access struct for the fixed-array insert/delete/search core. No dependencies.
package fais_pkg;

    localparam int SLOTS      = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WPTR_W     = IDX_W + 1;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W-1:0]  INS_START = IDX_W'(SLOTS - 2);
    localparam logic [WPTR_W-1:0] SLOTS_CNT = WPTR_W'(SLOTS);
    localparam logic [8:0]        POS_LIMIT = 9'(SLOTS);

    typedef logic [VALUE_BITS-1:0] t_word;

    typedef enum logic [2:0] {
        CMD_SHOW   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_DELALL = 3'd3,
        CMD_SEARCH = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STS_DONE      = 2'd0,
        STS_FOUND     = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_BAD_POS   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_FINISH
    } t_state;

    // one read and one write port of the entry table
    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_word            wdata;
    } t_tbl_req;

endpackage

>>> src/fixed_array_insert_delete_search_core.sv
// Fixed-array insert/delete/search core: top level, command sequencer and
// output register. Depends on fais_pkg and fais_table.
//
// One command at a time, tready low while it runs. Show and search walk all
// SLOTS entries through the single table read port (show stops early at the
// first empty slot). Delete-all walks SLOTS entries, then zero-fills the freed
// slots. Insert and delete walk between the position and the top. Result beats
// leave one per cycle; a sink stall holds the walk.
// Reset (i_rst_n low, synchronous) empties the table at once via valid bits.
module fixed_array_insert_delete_search_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] position, [39:8] item_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] command
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] slot_index, [39:8] slot_value
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);

    localparam int IW = fais_pkg::IDX_W;

    // sequencer state
    fais_pkg::t_state              r_state, n_state;
    fais_pkg::t_cmd                r_cmd, n_cmd;
    logic [7:0]                    r_pos, n_pos;
    fais_pkg::t_word               r_val, n_val;
    logic                          r_bad, n_bad;
    logic [IW-1:0]                 r_idx, n_idx;          // slot held in rdata
    logic [fais_pkg::WPTR_W-1:0]   r_wptr, n_wptr;        // delete-all write pointer
    fais_pkg::t_word               r_removed, n_removed;
    // held match/element: emitted once the next one (or the end) is known
    logic                          r_pend_valid, n_pend_valid;
    logic [IW-1:0]                 r_pend_idx, n_pend_idx;
    fais_pkg::t_word               r_pend_val, n_pend_val;

    // output register
    logic                          r_out_valid;
    fais_pkg::t_status             r_out_status;
    logic [7:0]                    r_out_index;
    logic [31:0]                   r_out_value;
    logic                          r_out_last;

    // beat to load into the output register this cycle
    logic                          emit;
    fais_pkg::t_status             em_status;
    logic [7:0]                    em_index;
    logic [31:0]                   em_value;
    logic                          em_last;

    fais_pkg::t_tbl_req            tbl_req;
    fais_pkg::t_word               rdata;
    logic                          out_free;
    fais_pkg::t_cmd                in_cmd;
    logic [7:0]                    in_pos;
    logic                          in_bad;

    fais_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rdata (rdata)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == fais_pkg::ST_IDLE);
    assign in_cmd        = fais_pkg::t_cmd'(s_axis_tuser);
    assign in_pos        = s_axis_tdata[7:0];
    assign in_bad        = ({1'b0, in_pos} >= fais_pkg::POS_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fais_pkg::ST_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_bad      <= n_bad;
        r_idx      <= n_idx;
        r_wptr     <= n_wptr;
        r_removed  <= n_removed;
        r_pend_idx <= n_pend_idx;
        r_pend_val <= n_pend_val;
        if (emit) begin
            r_out_status <= em_status;
            r_out_index  <= em_index;
            r_out_value  <= em_value;
            r_out_last   <= em_last;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_pos        = r_pos;
        n_val        = r_val;
        n_bad        = r_bad;
        n_idx        = r_idx;
        n_wptr       = r_wptr;
        n_removed    = r_removed;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_pend_val   = r_pend_val;
        emit         = 1'b0;
        em_status    = fais_pkg::STS_DONE;
        em_index     = '0;
        em_value     = '0;
        em_last      = 1'b0;
        tbl_req      = '0;

        unique case (r_state)
            fais_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd        = in_cmd;
                    n_pos        = in_pos;
                    n_val        = fais_pkg::VALUE_BITS'(signed'(s_axis_tdata[39:8]));
                    n_bad        = 1'b0;
                    n_wptr       = '0;
                    n_pend_valid = 1'b0;
                    unique case (in_cmd) inside
                        fais_pkg::CMD_SHOW, fais_pkg::CMD_SEARCH, fais_pkg::CMD_DELALL: begin
                            tbl_req.re    = 1'b1;
                            tbl_req.raddr = '0;
                            n_idx         = '0;
                            n_state       = fais_pkg::ST_SCAN;
                        end
                        fais_pkg::CMD_INSERT: begin
                            n_bad = in_bad;
                            if (in_bad || in_pos[IW-1:0] == fais_pkg::LAST_IDX) begin
                                // bad position or top slot: nothing to shift
                                n_state = fais_pkg::ST_FINISH;
                            end else begin
                                tbl_req.re    = 1'b1;
                                tbl_req.raddr = fais_pkg::INS_START;
                                n_idx         = fais_pkg::INS_START;
                                n_state       = fais_pkg::ST_SCAN;
                            end
                        end
                        fais_pkg::CMD_DELETE: begin
                            n_bad = in_bad;
                            if (in_bad) begin
                                n_state = fais_pkg::ST_FINISH;
                            end else begin
                                tbl_req.re    = 1'b1;
                                tbl_req.raddr = in_pos[IW-1:0];
                                n_idx         = in_pos[IW-1:0];
                                n_state       = fais_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            // unknown command: beat dropped, no result
                        end
                    endcase
                end
            end

            fais_pkg::ST_SCAN: begin
                unique case (r_cmd)
                    fais_pkg::CMD_SHOW: begin
                        if (rdata == '0) begin
                            n_state = fais_pkg::ST_FINISH;
                        end else if (!r_pend_valid || out_free) begin
                            if (r_pend_valid) begin
                                emit      = 1'b1;
                                em_status = fais_pkg::STS_FOUND;
                                em_index  = 8'(r_pend_idx);
                                em_value  = 32'(r_pend_val);
                            end
                            n_pend_valid = 1'b1;
                            n_pend_idx   = r_idx;
                            n_pend_val   = rdata;
                            if (r_idx == fais_pkg::LAST_IDX) begin
                                n_state = fais_pkg::ST_FINISH;
                            end else begin
                                n_idx         = r_idx + 1'b1;
                                tbl_req.re    = 1'b1;
                                tbl_req.raddr = r_idx + 1'b1;
                            end
                        end
                    end
                    fais_pkg::CMD_SEARCH: begin
                        if (!(rdata == r_val && r_pend_valid) || out_free) begin
                            if (rdata == r_val) begin
                                if (r_pend_valid) begin
                                    emit      = 1'b1;
                                    em_status = fais_pkg::STS_FOUND;
                                    em_index  = 8'(r_pend_idx);
                                    em_value  = 32'(r_pend_val);
                                end
                                n_pend_valid = 1'b1;
                                n_pend_idx   = r_idx;
                                n_pend_val   = rdata;
                            end
                            if (r_idx == fais_pkg::LAST_IDX) begin
                                n_state = fais_pkg::ST_FINISH;
                            end else begin
                                n_idx         = r_idx + 1'b1;
                                tbl_req.re    = 1'b1;
                                tbl_req.raddr = r_idx + 1'b1;
                            end
                        end
                    end
                    fais_pkg::CMD_INSERT: begin
                        // move entry up one slot, walking down to the position
                        tbl_req.we    = 1'b1;
                        tbl_req.waddr = r_idx + 1'b1;
                        tbl_req.wdata = rdata;
                        if (r_idx == r_pos[IW-1:0]) begin
                            n_state = fais_pkg::ST_FINISH;
                        end else begin
                            n_idx         = r_idx - 1'b1;
                            tbl_req.re    = 1'b1;
                            tbl_req.raddr = r_idx - 1'b1;
                        end
                    end
                    fais_pkg::CMD_DELETE: begin
                        if (r_idx == r_pos[IW-1:0]) begin
                            n_removed = rdata;
                        end else begin
                            tbl_req.we    = 1'b1;
                            tbl_req.waddr = r_idx - 1'b1;
                            tbl_req.wdata = rdata;
                        end
                        if (r_idx == fais_pkg::LAST_IDX) begin
                            n_state = fais_pkg::ST_FINISH;
                        end else begin
                            n_idx         = r_idx + 1'b1;
                            tbl_req.re    = 1'b1;
                            tbl_req.raddr = r_idx + 1'b1;
                        end
                    end
                    fais_pkg::CMD_DELALL: begin
                        // compact survivors; write pointer never passes the read
                        if (rdata != r_val) begin
                            tbl_req.we    = 1'b1;
                            tbl_req.waddr = r_wptr[IW-1:0];
                            tbl_req.wdata = rdata;
                            n_wptr        = r_wptr + 1'b1;
                        end
                        if (r_idx == fais_pkg::LAST_IDX) begin
                            n_state = fais_pkg::ST_FILL;
                        end else begin
                            n_idx         = r_idx + 1'b1;
                            tbl_req.re    = 1'b1;
                            tbl_req.raddr = r_idx + 1'b1;
                        end
                    end
                    default: begin
                        n_state = fais_pkg::ST_IDLE;
                    end
                endcase
            end

            fais_pkg::ST_FILL: begin
                // zero the slots above the compacted entries
                if (r_wptr == fais_pkg::SLOTS_CNT) begin
                    n_state = fais_pkg::ST_FINISH;
                end else begin
                    tbl_req.we    = 1'b1;
                    tbl_req.waddr = r_wptr[IW-1:0];
                    tbl_req.wdata = '0;
                    n_wptr        = r_wptr + 1'b1;
                end
            end

            fais_pkg::ST_FINISH: begin
                if (out_free) begin
                    emit    = 1'b1;
                    em_last = 1'b1;
                    n_state = fais_pkg::ST_IDLE;
                    if (r_bad) begin
                        em_status = fais_pkg::STS_BAD_POS;
                        em_index  = r_pos;
                    end else begin
                        case (r_cmd) inside
                            fais_pkg::CMD_SHOW, fais_pkg::CMD_SEARCH: begin
                                if (r_pend_valid) begin
                                    em_status = fais_pkg::STS_FOUND;
                                    em_index  = 8'(r_pend_idx);
                                    em_value  = 32'(r_pend_val);
                                end else if (r_cmd == fais_pkg::CMD_SEARCH) begin
                                    em_status = fais_pkg::STS_NOT_FOUND;
                                end
                            end
                            fais_pkg::CMD_INSERT: begin
                                tbl_req.we    = 1'b1;
                                tbl_req.waddr = r_pos[IW-1:0];
                                tbl_req.wdata = r_val;
                                em_index      = r_pos;
                                em_value      = 32'(r_val);
                            end
                            fais_pkg::CMD_DELETE: begin
                                tbl_req.we    = 1'b1;
                                tbl_req.waddr = fais_pkg::LAST_IDX;
                                tbl_req.wdata = '0;
                                em_index      = r_pos;
                                em_value      = 32'(r_removed);
                            end
                            default: begin
                                // delete-all: plain done beat
                            end
                        endcase
                    end
                end
            end

            default: begin
                n_state = fais_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_value, r_out_index};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> src/fais_table.sv
// fais_table: SLOTS-entry table, one write and one registered read per cycle.
// Per-entry valid bits make never-written entries read as zero after reset.
// Depends on fais_pkg.
module fais_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fais_pkg::t_tbl_req  i_req,
    output fais_pkg::t_word     o_rdata
);

    fais_pkg::t_word                r_mem [fais_pkg::SLOTS];
    logic [fais_pkg::SLOTS-1:0]     r_valid;
    fais_pkg::t_word                r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_valid[i_req.raddr] ? r_mem[i_req.raddr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;

endmodule
